[rtl/gfla_pkg.sv]
// gfla_pkg: shared codes and constants for the GF(2^m) log-domain ALU.
// Holds the action codes, the zero-element code and the primitive polynomials.
// No dependencies.
package gfla_pkg;

    // Action codes carried by the action field of a request
    typedef logic [2:0] action_t;

    localparam action_t ACT_ADD      = 3'd0;
    localparam action_t ACT_MUL      = 3'd1;
    localparam action_t ACT_DIV      = 3'd2;
    localparam action_t ACT_POW      = 3'd3;
    localparam action_t ACT_LOG2POLY = 3'd4;
    localparam action_t ACT_POLY2LOG = 3'd5;

    // Log-form code of the zero element
    localparam logic [7:0] ZERO_CODE = 8'hFF;

    // Low bits (below x^m) of the primitive polynomial for field size m
    function automatic logic [7:0] prim_low(input int unsigned bits);
        logic [7:0] val;
        case (bits)
            3:       val = 8'd3;    // x^3+x+1
            4:       val = 8'd3;    // x^4+x+1
            5:       val = 8'd5;    // x^5+x^2+1
            6:       val = 8'd3;    // x^6+x+1
            7:       val = 8'd3;    // x^7+x+1
            8:       val = 8'd29;   // x^8+x^4+x^3+x^2+1
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

[rtl/gf_log_domain_alu.sv]
// gf_log_domain_alu: GF(2^FIELD_BITS) arithmetic on elements in log form.
// Depends on gfla_pkg (action codes, zero code, primitive polynomials).
//
// Usage:
//   Request channel: in_valid / in_stall with action, operand_a, operand_b
//   and exponent. A request is taken at a clock edge with in_valid high and
//   in_stall low. Log-form operands use 255 as the zero element.
//   Response channel: out_valid / out_stall with result and divide_by_zero,
//   taken at an edge with out_valid high and out_stall low.
//   Every request gives exactly one response, in request order.
//   A request taken is loaded into the input register, worked through
//   table lookups and modular adds, and lands in the result register once
//   that register is free; from there it is offered as a response.
//   Throughput: one request per clock while out_stall is low; the path from input register to
//   result register (fold, multiply, fold) sets the clock.
//   A result held by a stalled receiver does not block the input register,
//   so one more request is taken; in_stall rises only when both registers
//   hold requests and out_stall is high.
//   Reset (rst_n low, asynchronous) empties both registers; there is no other
//   state, the antilog and log tables are constants.
module gf_log_domain_alu
    import gfla_pkg::*;
#(
    parameter int FIELD_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  operand_a,
    input  logic [7:0]  operand_b,
    input  logic [15:0] exponent,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  result,
    output logic        divide_by_zero
);

    localparam int TBL_SIZE = 1 << FIELD_BITS;
    localparam int ORDER    = TBL_SIZE - 1;
    localparam int CHUNKS   = (16 + FIELD_BITS - 1) / FIELD_BITS;
    localparam int FOLD_ROUNDS = 4;

    localparam logic [15:0]         ORDER16 = 16'(ORDER);
    localparam logic [FIELD_BITS:0] ORDER_W = (FIELD_BITS + 1)'(ORDER);

    typedef logic [TBL_SIZE-1:0][7:0] table_t;
    typedef logic [FIELD_BITS-1:0]    elem_t;

    // alpha^e in polynomial form for e below the group order
    function automatic table_t build_antilog();
        table_t     t;
        logic [7:0] p;
        logic       carry;
        t = '0;
        p = 8'd1;
        for (int e = 0; e < ORDER; e++)
        begin
            t[e]  = p;
            carry = p[FIELD_BITS-1];
            p     = (p << 1) & 8'(ORDER);
            if (carry)
                p = p ^ prim_low(FIELD_BITS);
        end
        return t;
    endfunction

    // Exponent of each nonzero polynomial; zero maps to the zero code
    function automatic table_t build_log();
        table_t     t;
        logic [7:0] p;
        logic       carry;
        for (int i = 0; i < TBL_SIZE; i++)
            t[i] = ZERO_CODE;
        p = 8'd1;
        for (int e = 0; e < ORDER; e++)
        begin
            t[p[FIELD_BITS-1:0]] = 8'(e);
            carry = p[FIELD_BITS-1];
            p     = (p << 1) & 8'(ORDER);
            if (carry)
                p = p ^ prim_low(FIELD_BITS);
        end
        return t;
    endfunction

    localparam table_t ANTILOG = build_antilog();
    localparam table_t LOG_TBL = build_log();

    // Reduce mod 2^m-1 by summing m-bit chunks (end-around carry folding)
    function automatic elem_t fold_mod(input logic [15:0] v);
        logic [15:0] acc;
        logic [15:0] nxt;
        acc = v;
        for (int r = 0; r < FOLD_ROUNDS; r++)
        begin
            nxt = '0;
            for (int c = 0; c < CHUNKS; c++)
                nxt = nxt + ((acc >> (c * FIELD_BITS)) & ORDER16);
            acc = nxt;
        end
        return (acc == ORDER16) ? '0 : acc[FIELD_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic        s1_valid_reg, s1_valid_next;
    action_t     s1_action_reg;
    logic [7:0]  s1_a_reg;
    logic [7:0]  s1_b_reg;
    logic [15:0] s1_exp_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  result_reg, result_next;
    logic        dz_reg, dz_next;

    logic out_free;
    logic s1_move;
    logic in_accept;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= action;
            s1_a_reg      <= operand_a;
            s1_b_reg      <= operand_b;
            s1_exp_reg    <= exponent;
        end
    end

    // ------------------------------------------------------------------
    // Field datapath
    // ------------------------------------------------------------------
    logic                     a_zero, b_zero;
    elem_t                    a_e, b_e;
    elem_t                    poly_a, poly_b;
    logic [FIELD_BITS:0]      mul_sum, div_diff;
    elem_t                    mul_e, div_e;
    elem_t                    n_mod, pow_e;
    logic [2*FIELD_BITS-1:0]  pow_prod;

    // Canonical exponents and polynomial forms of both operands
    assign a_zero = (s1_a_reg == ZERO_CODE);
    assign b_zero = (s1_b_reg == ZERO_CODE);
    assign a_e    = fold_mod(16'(s1_a_reg));
    assign b_e    = fold_mod(16'(s1_b_reg));
    assign poly_a = a_zero ? '0 : ANTILOG[a_e][FIELD_BITS-1:0];
    assign poly_b = b_zero ? '0 : ANTILOG[b_e][FIELD_BITS-1:0];

    // Exponent sum and difference mod 2^m-1
    assign mul_sum  = (FIELD_BITS + 1)'(a_e) + (FIELD_BITS + 1)'(b_e);
    assign mul_e    = (mul_sum >= ORDER_W) ? FIELD_BITS'(mul_sum - ORDER_W)
                                           : mul_sum[FIELD_BITS-1:0];
    assign div_diff = (a_e >= b_e) ? (FIELD_BITS + 1)'(a_e) - (FIELD_BITS + 1)'(b_e)
                                   : (FIELD_BITS + 1)'(a_e) + ORDER_W
                                     - (FIELD_BITS + 1)'(b_e);
    assign div_e    = div_diff[FIELD_BITS-1:0];

    // Power: reduce n first, then the product
    assign n_mod    = fold_mod(s1_exp_reg);
    assign pow_prod = (2 * FIELD_BITS)'(a_e) * (2 * FIELD_BITS)'(n_mod);
    assign pow_e    = fold_mod(16'(pow_prod));

    // Result select
    always_comb
    begin
        result_next = ZERO_CODE;
        dz_next     = 1'b0;
        case (s1_action_reg)
            ACT_ADD:
                result_next = LOG_TBL[poly_a ^ poly_b];
            ACT_MUL:
                if (!a_zero && !b_zero)
                    result_next = 8'(mul_e);
            ACT_DIV:
                if (b_zero)
                    dz_next = 1'b1;
                else if (!a_zero)
                    result_next = 8'(div_e);
            ACT_POW:
                if (a_zero)
                    result_next = (s1_exp_reg == 16'd0) ? 8'd0 : ZERO_CODE;
                else
                    result_next = 8'(pow_e);
            ACT_LOG2POLY:
                result_next = 8'(poly_a);
            ACT_POLY2LOG:
                result_next = LOG_TBL[s1_a_reg[FIELD_BITS-1:0]];
            default:
                result_next = ZERO_CODE;
        endcase
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            result_reg <= result_next;
            dz_reg     <= dz_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result         = result_reg;
    assign divide_by_zero = dz_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A flagged divide always returns the zero element
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> result == ZERO_CODE)
        else $error("divide_by_zero set with nonzero result");

    // Request side stalls only while the input register is occupied
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall raised with empty input register");

    // A request held in the input register is not dropped while blocked
    a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg)
        else $error("blocked request lost from input register");

    // A request moved forward shows up as a response next cycle
    a_move_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid)
        else $error("moved request did not reach result register");

endmodule

[verif/gf_log_domain_alu_tb.sv]
`timescale 1ns / 1ps
// gf_log_domain_alu_tb: self-checking bench for the GF(2^8) log-domain ALU.
// Checks every response against a bench-side field model, with random idling on both channels.
// Depends on gfla_pkg and rtl/gf_log_domain_alu.sv.
module gf_log_domain_alu_tb;
    import gfla_pkg::*;

    // Codes the package leaves unnamed: the two spare actions
    localparam action_t ACT_SPARE6 = 3'd6;
    localparam action_t ACT_SPARE7 = 3'd7;

    localparam int unsigned GF_ORDER    = 255;
    localparam logic [7:0]  GF_POLY_LOW = 8'd29;   // x^8+x^4+x^3+x^2+1 below x^8
    localparam int          RANDOM_REQS = 1000;
    localparam int          QUIET_TAIL  = 80;
    localparam int          IDLE_LIMIT  = 500;

    typedef struct {
        bit          drain;     // hold off until every response is back
        action_t     act;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] n;
    } gf_req_t;

    typedef struct {
        action_t    act;
        logic [7:0] res;
        logic       dz;
    } gf_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  action = ACT_ADD;
    logic [7:0]  operand_a = 8'd0;
    logic [7:0]  operand_b = 8'd0;
    logic [15:0] exponent = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  result;
    logic        divide_by_zero;

    gf_req_t  pending_reqs[$];
    gf_resp_t expected_resps[$];
    gf_req_t  next_req;
    gf_resp_t got_resp;
    int       send_gap = 0;
    int       stall_left = 0;
    int       idle_cycles = 0;
    int       errors = 0;
    int       resp_checked = 0;
    int       dz_seen = 0;
    int       act_count[8];

    gf_log_domain_alu dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .exponent       (exponent),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result         (result),
        .divide_by_zero (divide_by_zero)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------
    // Field model
    // ---------------------------------------------------------------

    // alpha^e in polynomial form, e below the group order
    function automatic logic [7:0] alpha_pow(input logic [7:0] e);
        logic [7:0] p;
        p = 8'd1;
        for (int i = 0; i < e; i++)
            p = {p[6:0], 1'b0} ^ (p[7] ? GF_POLY_LOW : 8'd0);
        return p;
    endfunction

    // discrete log of a polynomial-form element; zero maps to the zero code
    function automatic logic [7:0] poly_to_exp(input logic [7:0] poly);
        logic [7:0] p;
        p = 8'd1;
        if (poly == 8'd0)
            return ZERO_CODE;
        for (int e = 0; e < GF_ORDER; e++)
        begin
            if (p == poly)
                return 8'(e);
            p = {p[6:0], 1'b0} ^ (p[7] ? GF_POLY_LOW : 8'd0);
        end
        return ZERO_CODE;
    endfunction

    // log code to polynomial form; at 8 bits every nonzero code is already canonical
    function automatic logic [7:0] exp_to_poly(input logic [7:0] lg);
        return (lg == ZERO_CODE) ? 8'd0 : alpha_pow(lg);
    endfunction

    function automatic gf_resp_t gf_compute(input action_t act, input logic [7:0] a,
                                            input logic [7:0] b, input logic [15:0] n);
        gf_resp_t r;
        int unsigned ia;
        int unsigned ib;
        ia = a;
        ib = b;
        r.act = act;
        r.res = ZERO_CODE;
        r.dz  = 1'b0;
        case (act)
            ACT_ADD:      r.res = poly_to_exp(exp_to_poly(a) ^ exp_to_poly(b));
            ACT_MUL:
            begin
                if (a != ZERO_CODE && b != ZERO_CODE)
                    r.res = 8'((ia + ib) % GF_ORDER);
            end
            ACT_DIV:
            begin
                if (b == ZERO_CODE)
                    r.dz = 1'b1;
                else if (a != ZERO_CODE)
                    r.res = 8'((ia + GF_ORDER - ib) % GF_ORDER);
            end
            ACT_POW:
            begin
                // zero to the zeroth is one (log 0)
                if (a == ZERO_CODE)
                    r.res = (n == 16'd0) ? 8'd0 : ZERO_CODE;
                else
                    r.res = 8'((ia * int'(n)) % GF_ORDER);
            end
            ACT_LOG2POLY: r.res = exp_to_poly(a);
            ACT_POLY2LOG: r.res = poly_to_exp(a);
            default:      ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic queue_req(input bit drain, input action_t act, input logic [7:0] a,
                             input logic [7:0] b, input logic [15:0] n);
        gf_req_t r;
        r.drain = drain;
        r.act   = act;
        r.a     = a;
        r.b     = b;
        r.n     = n;
        pending_reqs.push_back(r);
    endtask

    // log operand biased toward zero and the ends of the exponent range
    function automatic logic [7:0] pick_log();
        case ($urandom_range(0, 7))
            0:       return ZERO_CODE;
            1:       return 8'($urandom_range(0, 2) == 0 ? 254 : $urandom_range(0, 1));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_power();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'($urandom_range(0, 300));
            2:       return 16'($urandom_range(0, 1) ? 65535 : 255 * $urandom_range(1, 257));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // idling stays off in the tail and in one window out of every 200 requests
    function automatic bit idling_on();
        return pending_reqs.size() > QUIET_TAIL && (pending_reqs.size() % 200) >= 40;
    endfunction

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_reqs.size() == 0)
                in_valid <= 1'b0;
            else if (pending_reqs[0].drain)
            begin
                // pause until the response side has caught up
                in_valid <= 1'b0;
                if (!in_valid && expected_resps.size() == 0)
                    void'(pending_reqs.pop_front());
            end
            else if (in_valid && idling_on() && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(1, 11) - 1;
            end
            else
            begin
                next_req = pending_reqs.pop_front();
                in_valid  <= 1'b1;
                action    <= next_req.act;
                operand_a <= next_req.a;
                operand_b <= next_req.b;
                exponent  <= next_req.n;
            end
        end
    end

    // ---------------------------------------------------------------
    // Response-side back-pressure
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idling_on() && $urandom_range(0, 9) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 11) - 1;
        end
        else
            out_stall <= 1'b0;
    end

    // ---------------------------------------------------------------
    // Monitor: check responses, then predict for the request taken now
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_resps.size() == 0)
                begin
                    $display("%0t: response with none pending: result %0d, flag %0b",
                             $time, result, divide_by_zero);
                    errors++;
                end
                else
                begin
                    got_resp = expected_resps.pop_front();
                    resp_checked++;
                    if (result !== got_resp.res)
                    begin
                        $display("%0t: result mismatch (action %0d): expected %0d, actual %0d",
                                 $time, got_resp.act, got_resp.res, result);
                        errors++;
                    end
                    if (divide_by_zero !== got_resp.dz)
                    begin
                        $display("%0t: divide_by_zero mismatch (action %0d): expected %0b, actual %0b",
                                 $time, got_resp.act, got_resp.dz, divide_by_zero);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                got_resp = gf_compute(action_t'(action), operand_a, operand_b, exponent);
                expected_resps.push_back(got_resp);
                act_count[action]++;
                if (got_resp.dz)
                    dz_seen++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: too long without any transfer on either channel
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        action_t act;
        foreach (act_count[i])
            act_count[i] = 0;

        // directed: zero element, ends of the exponent range, every action
        queue_req(0, ACT_ADD,      ZERO_CODE, ZERO_CODE, 16'd0);
        queue_req(0, ACT_ADD,      8'd0,      8'd0,      16'd0);     // x + x = 0
        queue_req(0, ACT_ADD,      8'd254,    8'd1,      16'd0);
        queue_req(0, ACT_ADD,      8'd7,      ZERO_CODE, 16'd0);
        queue_req(0, ACT_MUL,      8'd254,    8'd254,    16'd0);
        queue_req(0, ACT_MUL,      ZERO_CODE, 8'd5,      16'd0);
        queue_req(0, ACT_MUL,      8'd254,    8'd1,      16'd0);     // wraps to one
        queue_req(0, ACT_DIV,      ZERO_CODE, ZERO_CODE, 16'd0);     // zero over zero
        queue_req(0, ACT_DIV,      8'd7,      ZERO_CODE, 16'd0);     // divide by zero
        queue_req(0, ACT_DIV,      ZERO_CODE, 8'd7,      16'd0);     // zero dividend
        queue_req(0, ACT_DIV,      8'd0,      8'd1,      16'd0);
        queue_req(0, ACT_DIV,      8'd254,    8'd254,    16'd0);
        queue_req(0, ACT_POW,      ZERO_CODE, 8'd0,      16'd0);     // zero to the zeroth
        queue_req(0, ACT_POW,      ZERO_CODE, 8'd0,      16'd1);
        queue_req(0, ACT_POW,      8'd254,    8'd0,      16'hFFFF);
        queue_req(0, ACT_POW,      8'd1,      8'd0,      16'd255);
        queue_req(0, ACT_POW,      8'd0,      8'd0,      16'd0);
        queue_req(0, ACT_LOG2POLY, 8'd0,      8'd0,      16'd0);
        queue_req(0, ACT_LOG2POLY, 8'd254,    8'd0,      16'd0);
        queue_req(0, ACT_LOG2POLY, ZERO_CODE, 8'd0,      16'd0);
        queue_req(0, ACT_POLY2LOG, 8'd0,      8'd0,      16'd0);     // zero polynomial
        queue_req(0, ACT_POLY2LOG, 8'd255,    8'd0,      16'd0);
        queue_req(0, ACT_POLY2LOG, 8'd1,      8'd0,      16'd0);
        queue_req(0, ACT_SPARE6,   8'd3,      ZERO_CODE, 16'd9);
        queue_req(0, ACT_SPARE7,   8'd0,      8'd0,      16'hFFFF);
        queue_req(1, ACT_ADD, 8'd0, 8'd0, 16'd0);

        // random requests, with a second full drain halfway through
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i == RANDOM_REQS / 2)
                queue_req(1, ACT_ADD, 8'd0, 8'd0, 16'd0);
            if ($urandom_range(0, 31) == 0)
                act = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
            else
                act = action_t'($urandom_range(0, 5));
            queue_req(0, act, pick_log(), pick_log(), pick_power());
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Covered %0d responses: add %0d, mul %0d, div %0d, pow %0d, log->poly %0d,",
                 resp_checked, act_count[ACT_ADD], act_count[ACT_MUL], act_count[ACT_DIV],
                 act_count[ACT_POW], act_count[ACT_LOG2POLY]);
        $display("  poly->log %0d, spare actions %0d, divide-by-zero flagged %0d, errors %0d",
                 act_count[ACT_POLY2LOG], act_count[ACT_SPARE6] + act_count[ACT_SPARE7],
                 dz_seen, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
